// ===== hdl/lrts_pkg.sv =====
// Shared constants, sequencer states and table control type for the scheduler.
package lrts_pkg;

   // Default sizes of the job table and its fields
   localparam int DEF_JOB_SLOTS  = 4;
   localparam int DEF_TIME_BITS  = 16;
   localparam int DEF_BURST_BITS = 8;

   // Width of the slot field on both channels
   localparam int SLOT_FIELD_BITS = 2;

   // Command codes carried in the request tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_STEP,
      ST_TAT,
      ST_WAIT,
      ST_DONE
   } state_type;

   // Write strobes into the job table
   typedef struct packed {
      logic load;
      logic dec;
   } tbl_ctl_type;

endpackage

// ===== hdl/longest_remaining_time_scheduler.sv =====
// Longest-remaining-time-first scheduler: sequencer, shared subtractor, result register.
//
//   channel  dir  ports                      content
//   req      in   req_tvalid/tready/tdata/   load a job slot or one time tick
//                 tuser
//   rsp      out  rsp_tvalid/tready/tdata    one result per item
//
// A load item passes through LOAD and DONE. A tick passes through SCAN and STEP,
// plus TAT and WAIT if the chosen job finishes, then DONE: the scan visits one slot per
// cycle through a single table read port and comparator, and one subtractor
// serves the decrement, the turnaround and the waiting time in turn.
// Reset clears the job table and the clock. A stalled result waits in the output
// register; the next item is taken while it waits, and the sequencer holds at
// its last step only when a second result would be produced.
module longest_remaining_time_scheduler #(
   parameter int JOB_SLOTS  = lrts_pkg::DEF_JOB_SLOTS,
   parameter int TIME_BITS  = lrts_pkg::DEF_TIME_BITS,
   parameter int BURST_BITS = lrts_pkg::DEF_BURST_BITS,
   localparam int REQ_FIELDS    = lrts_pkg::SLOT_FIELD_BITS + TIME_BITS + BURST_BITS,
   localparam int REQ_DATA_BITS = ((REQ_FIELDS + 7) / 8) * 8,
   localparam int RSP_FIELDS    = lrts_pkg::SLOT_FIELD_BITS + 4 + 3 * TIME_BITS,
   localparam int RSP_DATA_BITS = ((RSP_FIELDS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // slot, arrival, burst (from bit 0 up)
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // cmd
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // ran, chosen_slot, finished, completion_time, turnaround, waiting, all_done
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);
   import lrts_pkg::*;

   localparam int SLOT_BITS = $clog2(JOB_SLOTS);
   localparam int UNIT_BITS = ((TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS) + 1;

   state_type             state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [SLOT_FIELD_BITS-1:0] slot_ff, slot_in;
   logic [TIME_BITS-1:0]  arrival_ff, arrival_in;
   logic [BURST_BITS-1:0] burst_ff, burst_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic                  best_valid_ff, best_valid_in;
   logic [SLOT_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [BURST_BITS-1:0] best_rem_ff, best_rem_in;
   logic [TIME_BITS-1:0]  best_arr_ff, best_arr_in;
   logic [BURST_BITS-1:0] best_orig_ff, best_orig_in;
   logic [TIME_BITS-1:0]  clock_ff, clock_in;
   logic                  ran_ff, ran_in;
   logic                  fin_ff, fin_in;
   logic [TIME_BITS-1:0]  tat_ff, tat_in;
   logic [TIME_BITS-1:0]  wait_ff, wait_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   tbl_ctl_type           tbl_ctl;
   logic [SLOT_BITS-1:0]  tbl_wr_idx;
   logic [BURST_BITS-1:0] tbl_wr_burst;
   logic [TIME_BITS-1:0]  rd_arrival;
   logic [BURST_BITS-1:0] rd_remaining;
   logic [BURST_BITS-1:0] rd_original;
   logic                  all_done;

   logic                  req_accept;
   logic                  out_free;
   logic                  slot_in_range;
   logic                  scan_last;
   logic                  eligible;
   logic                  better;
   logic [UNIT_BITS-1:0]  unit_a, unit_b, unit_diff;
   logic                  unit_borrow;

   assign req_accept    = req_tvalid && req_tready;
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign slot_in_range = int'(slot_ff) < JOB_SLOTS;
   assign scan_last     = int'(idx_ff) == JOB_SLOTS - 1;

   // Compare the scanned slot against the best so far
   assign eligible = (rd_remaining != '0) && (rd_arrival <= clock_ff);
   assign better   = !best_valid_ff || (rd_remaining > best_rem_ff);

   // Shared subtractor: decrement, turnaround, waiting
   assign unit_diff   = unit_a - unit_b;
   assign unit_borrow = unit_diff[UNIT_BITS-1];

   lrts_table #(
      .JOB_SLOTS  (JOB_SLOTS),
      .TIME_BITS  (TIME_BITS),
      .BURST_BITS (BURST_BITS),
      .SLOT_BITS  (SLOT_BITS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .ctl          (tbl_ctl),
      .wr_idx       (tbl_wr_idx),
      .wr_arrival   (arrival_ff),
      .wr_burst     (tbl_wr_burst),
      .rd_idx       (idx_ff),
      .rd_arrival   (rd_arrival),
      .rd_remaining (rd_remaining),
      .rd_original  (rd_original),
      .all_done     (all_done)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == CMD_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: state_in = ST_DONE;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (best_valid_ff && (best_rem_ff == BURST_BITS'(1))) begin
               state_in = ST_TAT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TAT:  state_in = ST_WAIT;
         ST_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs: handshake, table strobes, subtractor operands
   always_comb begin
      req_tready   = 1'b0;
      tbl_ctl      = '0;
      tbl_wr_idx   = SLOT_BITS'(slot_ff);
      tbl_wr_burst = burst_ff;
      unit_a       = UNIT_BITS'(best_rem_ff);
      unit_b       = UNIT_BITS'(1);
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_LOAD: tbl_ctl.load = slot_in_range;
         ST_SCAN: ;
         ST_STEP: begin
            tbl_ctl.dec  = best_valid_ff;
            tbl_wr_idx   = best_idx_ff;
            tbl_wr_burst = unit_diff[BURST_BITS-1:0];
         end
         ST_TAT: begin
            unit_a = UNIT_BITS'(clock_ff);
            unit_b = UNIT_BITS'(best_arr_ff);
         end
         ST_WAIT: begin
            unit_a = UNIT_BITS'(tat_ff);
            unit_b = UNIT_BITS'(best_orig_ff);
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      arrival_in    = arrival_ff;
      burst_in      = burst_ff;
      idx_in        = idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_rem_in   = best_rem_ff;
      best_arr_in   = best_arr_ff;
      best_orig_in  = best_orig_ff;
      clock_in      = clock_ff;
      ran_in        = ran_ff;
      fin_in        = fin_ff;
      tat_in        = tat_ff;
      wait_in       = wait_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // capture the item and clear the result fields
            if (req_accept) begin
               cmd_in        = req_tuser;
               slot_in       = req_tdata[SLOT_FIELD_BITS-1:0];
               arrival_in    = req_tdata[SLOT_FIELD_BITS +: TIME_BITS];
               burst_in      = req_tdata[SLOT_FIELD_BITS + TIME_BITS +: BURST_BITS];
               idx_in        = '0;
               best_valid_in = 1'b0;
               best_idx_in   = '0;
               ran_in        = 1'b0;
               fin_in        = 1'b0;
               tat_in        = '0;
               wait_in       = '0;
            end
         end
         ST_LOAD: clock_in = '0;
         ST_SCAN: begin
            // keep the longest eligible burst, lowest slot on ties
            if (eligible && better) begin
               best_valid_in = 1'b1;
               best_idx_in   = idx_ff;
               best_rem_in   = rd_remaining;
               best_arr_in   = rd_arrival;
               best_orig_in  = rd_original;
            end
            idx_in = idx_ff + SLOT_BITS'(1);
         end
         ST_STEP: begin
            // advance the clock, saturating
            if (clock_ff != '1) begin
               clock_in = clock_ff + TIME_BITS'(1);
            end
            ran_in = best_valid_ff;
            fin_in = best_valid_ff && (best_rem_ff == BURST_BITS'(1));
         end
         ST_TAT:  tat_in = unit_diff[TIME_BITS-1:0];
         ST_WAIT: wait_in = unit_borrow ? '0 : unit_diff[TIME_BITS-1:0];
         ST_DONE: begin
            // hand the result to the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'({all_done, wait_ff, tat_ff, clock_ff, fin_ff,
                                              SLOT_FIELD_BITS'(best_idx_ff), ran_ff});
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      arrival_ff    <= arrival_in;
      burst_ff      <= burst_in;
      idx_ff        <= idx_in;
      best_valid_ff <= best_valid_in;
      best_idx_ff   <= best_idx_in;
      best_rem_ff   <= best_rem_in;
      best_arr_ff   <= best_arr_in;
      best_orig_ff  <= best_orig_in;
      ran_ff        <= ran_in;
      fin_ff        <= fin_in;
      tat_ff        <= tat_in;
      wait_ff       <= wait_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A tick that scans never follows a load capture
   a_scan_is_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cmd_ff == CMD_TICK))
      else $error("scan running for a load item");

   // Busy after every accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("item accepted while busy");

   // A finished job must have run
   a_fin_needs_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!fin_ff || ran_ff))
      else $error("finished without a running job");

   // Waiting never exceeds turnaround
   a_wait_le_tat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (wait_ff <= tat_ff))
      else $error("waiting above turnaround");

endmodule

// ===== hdl/lrts_table.sv =====
// Job table: arrival, remaining and original burst per slot, one read port.
module lrts_table #(
   parameter int JOB_SLOTS  = lrts_pkg::DEF_JOB_SLOTS,
   parameter int TIME_BITS  = lrts_pkg::DEF_TIME_BITS,
   parameter int BURST_BITS = lrts_pkg::DEF_BURST_BITS,
   parameter int SLOT_BITS  = $clog2(JOB_SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrts_pkg::tbl_ctl_type  ctl,
   input  logic [SLOT_BITS-1:0]   wr_idx,
   input  logic [TIME_BITS-1:0]   wr_arrival,
   input  logic [BURST_BITS-1:0]  wr_burst,
   input  logic [SLOT_BITS-1:0]   rd_idx,
   output logic [TIME_BITS-1:0]   rd_arrival,
   output logic [BURST_BITS-1:0]  rd_remaining,
   output logic [BURST_BITS-1:0]  rd_original,
   output logic                   all_done
);
   import lrts_pkg::*;

   logic [TIME_BITS-1:0]  arrival_ff   [JOB_SLOTS];
   logic [BURST_BITS-1:0] remaining_ff [JOB_SLOTS];
   logic [BURST_BITS-1:0] original_ff  [JOB_SLOTS];

   // Write a loaded job, or store a decremented burst
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < JOB_SLOTS; k++) begin
            arrival_ff[k]   <= '0;
            remaining_ff[k] <= '0;
            original_ff[k]  <= '0;
         end
      end else if (ctl.load) begin
         arrival_ff[wr_idx]   <= wr_arrival;
         remaining_ff[wr_idx] <= wr_burst;
         original_ff[wr_idx]  <= wr_burst;
      end else if (ctl.dec) begin
         remaining_ff[wr_idx] <= wr_burst;
      end
   end

   // Read the slot under scan
   assign rd_arrival   = arrival_ff[rd_idx];
   assign rd_remaining = remaining_ff[rd_idx];
   assign rd_original  = original_ff[rd_idx];

   // Flag an empty table
   always_comb begin
      all_done = 1'b1;
      for (int k = 0; k < JOB_SLOTS; k++) begin
         if (remaining_ff[k] != '0) begin
            all_done = 1'b0;
         end
      end
   end

endmodule

// ===== dv/tb_longest_remaining_time_scheduler.sv =====
// Self-checking testbench for the longest-remaining-time-first job scheduler.
module tb_longest_remaining_time_scheduler;
   import lrts_pkg::*;

   localparam int SLOTS   = DEF_JOB_SLOTS;
   localparam int TBITS   = DEF_TIME_BITS;
   localparam int BBITS   = DEF_BURST_BITS;
   localparam int REQ_W   = ((SLOT_FIELD_BITS + TBITS + BBITS + 7) / 8) * 8;
   localparam int RSP_W   = ((SLOT_FIELD_BITS + 4 + 3 * TBITS + 7) / 8) * 8;
   localparam logic [TBITS-1:0] TIME_MAX = '1;

   // One request item: command in tuser, slot/arrival/burst in tdata
   typedef struct {
      logic                       cmd;
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic [TBITS-1:0]           arrival;
      logic [BBITS-1:0]           burst;
      bit                         drain;
   } job_item_type;

   // One scheduling result
   typedef struct {
      logic                       ran;
      logic [SLOT_FIELD_BITS-1:0] chosen;
      logic                       finished;
      logic [TBITS-1:0]           completion;
      logic [TBITS-1:0]           turnaround;
      logic [TBITS-1:0]           waiting;
      logic                       all_done;
   } sched_result_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   longest_remaining_time_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted job table and clock
   logic [TBITS-1:0] job_arrival [SLOTS];
   logic [BBITS-1:0] job_left    [SLOTS];
   logic [BBITS-1:0] job_burst   [SLOTS];
   logic [TBITS-1:0] sched_clock;

   job_item_type     pending_items [$];
   sched_result_type sched_expect  [$];
   bit               offering = 1'b0;
   int               errors = 0;
   int               results_seen = 0;
   int               hold_at = -1;
   int               hold_left = 0;
   int               cycle = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle <= cycle + 1;

   // Random idle roll shared by both sides, off during one long window
   function automatic bit take_break();
      if (cycle >= 3000 && cycle < 6000) return 1'b0;
      return $urandom_range(0, 99) < 13;
   endfunction

   // Apply one item to the predicted table and compute its result
   task automatic schedule_step(input job_item_type it, output sched_result_type r);
      int best;
      r = '{default: '0};
      best = -1;
      if (it.cmd == CMD_LOAD) begin
         job_arrival[it.slot] = it.arrival;
         job_left[it.slot]    = it.burst;
         job_burst[it.slot]   = it.burst;
         sched_clock = '0;
      end else begin
         for (int k = 0; k < SLOTS; k++) begin
            if (job_left[k] != 0 && job_arrival[k] <= sched_clock) begin
               if (best < 0 || job_left[k] > job_left[best]) best = k;
            end
         end
         if (sched_clock != TIME_MAX) sched_clock = sched_clock + 1'b1;
         if (best >= 0) begin
            r.ran    = 1'b1;
            r.chosen = best[SLOT_FIELD_BITS-1:0];
            job_left[best] = job_left[best] - 1'b1;
            if (job_left[best] == 0) begin
               r.finished   = 1'b1;
               r.turnaround = sched_clock - job_arrival[best];
               r.waiting    = (r.turnaround > TBITS'(job_burst[best])) ?
                              r.turnaround - TBITS'(job_burst[best]) : '0;
            end
         end
      end
      r.completion = sched_clock;
      r.all_done   = 1'b1;
      for (int k = 0; k < SLOTS; k++) begin
         if (job_left[k] != 0) r.all_done = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [TBITS-1:0] want,
                              input logic [TBITS-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic add_load(input int slot, input int arr, input int burst);
      job_item_type it;
      it.cmd     = CMD_LOAD;
      it.slot    = SLOT_FIELD_BITS'(slot);
      it.arrival = TBITS'(arr);
      it.burst   = BBITS'(burst);
      it.drain   = 1'b0;
      pending_items.push_back(it);
   endtask

   // Tick items carry random, ignored payload
   task automatic add_ticks(input int n);
      job_item_type it;
      for (int i = 0; i < n; i++) begin
         it.cmd     = CMD_TICK;
         it.slot    = SLOT_FIELD_BITS'($urandom);
         it.arrival = TBITS'($urandom);
         it.burst   = BBITS'($urandom);
         it.drain   = 1'b0;
         pending_items.push_back(it);
      end
   endtask

   // Driver: offer the oldest pending item, hold it until accepted
   always @(posedge clock) begin
      job_item_type     cur;
      sched_result_type r;
      if (reset) begin
         offering = 1'b0;
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            cur = pending_items.pop_front();
            schedule_step(cur, r);
            sched_expect.push_back(r);
            offering = 1'b0;
         end
         if (!offering && pending_items.size() > 0) begin
            if (!(pending_items[0].drain && sched_expect.size() != 0) && !take_break()) begin
               offering = 1'b1;
               req_tuser <= pending_items[0].cmd;
               req_tdata <= {{(REQ_W - SLOT_FIELD_BITS - TBITS - BBITS){1'b0}},
                             pending_items[0].burst, pending_items[0].arrival,
                             pending_items[0].slot};
            end
         end
         req_tvalid <= offering;
      end
   end

   // Monitor: check each accepted result, drive ready with idles and one long hold
   always @(posedge clock) begin
      sched_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sched_expect.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            end else begin
               e = sched_expect.pop_front();
               check_field("ran", TBITS'(e.ran), TBITS'(rsp_tdata[0]));
               check_field("chosen_slot", TBITS'(e.chosen), TBITS'(rsp_tdata[2:1]));
               check_field("finished", TBITS'(e.finished), TBITS'(rsp_tdata[3]));
               check_field("completion_time", e.completion, rsp_tdata[19:4]);
               check_field("turnaround", e.turnaround, rsp_tdata[35:20]);
               check_field("waiting", e.waiting, rsp_tdata[51:36]);
               check_field("all_done", TBITS'(e.all_done), TBITS'(rsp_tdata[52]));
            end
            results_seen++;
            if (results_seen == hold_at) hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !take_break();
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int directed_n, seq, kind, sum, amax, r, first;
      int arr [SLOTS];
      int bur [SLOTS];

      for (int k = 0; k < SLOTS; k++) begin
         job_arrival[k] = '0;
         job_left[k]    = '0;
         job_burst[k]   = '0;
      end
      sched_clock = '0;

      // Directed: idle on empty table, extremes, tie, late arrival, early reload
      add_ticks(1);
      add_load(0, 0, 0);
      add_load(3, 16'hFFFF, 8'hFF);
      add_ticks(2);
      add_load(3, 0, 1);
      add_load(1, 0, 3);
      add_load(2, 0, 3);
      add_load(0, 1, 2);
      add_ticks(10);
      add_load(0, 0, 3);
      add_ticks(2);
      add_load(1, 0, 0);
      add_ticks(2);
      directed_n = pending_items.size();

      // Random: mostly full schedules, some cut short, some noise
      seq = 0;
      while (pending_items.size() < directed_n + 1050) begin
         first = pending_items.size();
         kind = $urandom_range(0, 9);
         if (kind <= 8) begin
            sum = 0;
            amax = 0;
            for (int k = 0; k < SLOTS; k++) begin
               r = $urandom_range(0, 99);
               bur[k] = (r < 8) ? 0 : (r < 12) ? $urandom_range(0, 255) : $urandom_range(1, 9);
               arr[k] = ($urandom_range(0, 99) < 6) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 12);
               if (arr[k] <= 12) begin
                  sum += bur[k];
                  if (arr[k] > amax) amax = arr[k];
               end
            end
            for (int k = 0; k < SLOTS; k++) begin
               if (kind <= 6 || $urandom_range(0, 1)) add_load(k, arr[k], bur[k]);
            end
            if (kind <= 6) add_ticks(sum + amax + $urandom_range(0, 3));
            else add_ticks($urandom_range(1, 8));
         end else begin
            for (int i = $urandom_range(1, 6); i > 0; i--) begin
               if ($urandom_range(0, 1)) add_ticks(1);
               else add_load($urandom_range(0, 3), $urandom_range(0, 65535),
                             $urandom_range(0, 255));
            end
         end
         if (seq == 10) pending_items[first].drain = 1'b1;
         seq++;
      end
      hold_at = directed_n + 150;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || offering) @(posedge clock);
      while (sched_expect.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #60000000;
      $display("Verification failed");
      $finish;
   end

endmodule
